// ----- src/ledsbm_pkg.sv -----
// ----------------------------------------------------------------------------
// LED driver serial bus master package
// Shared types and constants for the command front end and the pin sequencer.
// ----------------------------------------------------------------------------
package ledsbm_pkg;

   // Request codes on the input channel.
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_WRITE = 3'd2;
   localparam logic [2:0] REQ_READ  = 3'd3;
   localparam logic [2:0] REQ_STOP  = 3'd4;

   // Wire modes.
   localparam logic [1:0] MODE_TWO_WIRE = 2'd0;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIRE_MODE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD = 1'b1;
   localparam int unsigned CSR_DATA_WIDTH = 12;

   localparam logic [3:0] BYTE_BITS = 4'd8;

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_START,
      KIND_WRITE,
      KIND_READ,
      KIND_STOP
   } kind_type;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ST2,
      PH_ST3A,
      PH_ST3B,
      PH_WR_LO,
      PH_WR_HI,
      PH_ACK_LO,
      PH_ACK_HI,
      PH_RD_REL,
      PH_RD_LO,
      PH_RD_HI,
      PH_SP2A,
      PH_SP2B,
      PH_SP2C,
      PH_SP3A
   } phase_type;

   // One classified item as it sits in the command queue.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_value;
      logic       serial_in;
   } item_type;

   // Handshake between the queue head and the sequencer.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ----- src/ledsbm_front.sv -----
// ----------------------------------------------------------------------------
// LED driver serial bus master front end
// Accepts request beats, classifies the request code and holds the items in
// a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module ledsbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic [7:0]          req_byte_value,
   input  logic                req_serial_in,
   output ledsbm_pkg::head_type head,
   input  logic                pop
);

   ledsbm_pkg::item_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   ledsbm_pkg::item_type item_new;
   logic                 push;

   // Unused request codes behave as ticks.
   always_comb begin
      item_new.byte_value = req_byte_value;
      item_new.serial_in  = req_serial_in;
      case (req_type)
         ledsbm_pkg::REQ_START: item_new.kind = ledsbm_pkg::KIND_START;
         ledsbm_pkg::REQ_WRITE: item_new.kind = ledsbm_pkg::KIND_WRITE;
         ledsbm_pkg::REQ_READ:  item_new.kind = ledsbm_pkg::KIND_READ;
         ledsbm_pkg::REQ_STOP:  item_new.kind = ledsbm_pkg::KIND_STOP;
         default:               item_new.kind = ledsbm_pkg::KIND_TICK;
      endcase
   end

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ----- src/ledsbm_back.sv -----
// ----------------------------------------------------------------------------
// LED driver serial bus master sequencer
// Executes one queued item per cycle, unless the response stalls, against the
// pin phase machine. The state registers are also the output result register.
// ----------------------------------------------------------------------------
module ledsbm_back #(
   parameter int DELAY_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ledsbm_pkg::head_type head,
   output logic                 pop,
   input  logic [1:0]           wire_mode,
   input  logic [11:0]          half_period,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_clk_out,
   output logic                 rsp_dio_out,
   output logic                 rsp_dio_drive,
   output logic                 rsp_stb_out,
   output logic                 rsp_busy_res,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_read_valid,
   output logic                 rsp_ack_ok,
   output logic                 rsp_op_done,
   output logic                 rsp_rejected
);

   localparam logic [DELAY_BITS-1:0] WaitMax = '1;
   localparam logic [DELAY_BITS-1:0] WaitOne = {{(DELAY_BITS-1){1'b0}}, 1'b1};

   ledsbm_pkg::phase_type phase_ff, phase_in;
   logic [3:0]            bit_count_ff, bit_count_in;
   logic [DELAY_BITS-1:0] wait_ff, wait_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            tx_ff, tx_in;
   logic                  clk_ff, clk_in;
   logic                  dio_ff, dio_in;
   logic                  stb_ff, stb_in;
   logic                  drv_ff, drv_in;
   logic                  ack_ff, ack_in;
   logic                  rv_ff, rv_in;
   logic                  done_ff, done_in;
   logic                  rej_ff, rej_in;
   logic                  valid_ff;

   logic                  two_wire;
   logic                  four_wire;
   logic [31:0]           hp_wide;
   logic [DELAY_BITS-1:0] wait_load;
   logic [DELAY_BITS-1:0] wait_dec;
   logic [3:0]            bit_next;

   assign pop       = head.valid && (!valid_ff || rsp_ready);
   assign two_wire  = (wire_mode == ledsbm_pkg::MODE_TWO_WIRE);
   assign four_wire = wire_mode[1];
   assign wait_dec  = wait_ff - WaitOne;
   assign bit_next  = bit_count_ff + 4'd1;
   assign hp_wide   = 32'(half_period);

   // Phase length, with zero read as one and saturation to the counter range.
   always_comb begin
      if (hp_wide > 32'(WaitMax)) begin
         wait_load = WaitMax;
      end else if (half_period == 12'd0) begin
         wait_load = WaitOne;
      end else begin
         wait_load = hp_wide[DELAY_BITS-1:0];
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      tx_in        = tx_ff;
      clk_in       = clk_ff;
      dio_in       = dio_ff;
      stb_in       = stb_ff;
      drv_in       = drv_ff;
      ack_in       = ack_ff;
      rv_in        = 1'b0;
      done_in      = 1'b0;
      rej_in       = 1'b0;

      if (head.item.kind != ledsbm_pkg::KIND_TICK) begin
         if (phase_ff != ledsbm_pkg::PH_IDLE) begin
            rej_in = 1'b1;
         end else begin
            wait_in = wait_load;
            case (head.item.kind)
               ledsbm_pkg::KIND_START: begin
                  drv_in = 1'b1;
                  clk_in = 1'b1;
                  if (two_wire) begin
                     dio_in   = 1'b1;
                     phase_in = ledsbm_pkg::PH_ST2;
                  end else begin
                     dio_in   = 1'b0;
                     phase_in = ledsbm_pkg::PH_ST3A;
                  end
               end
               ledsbm_pkg::KIND_WRITE: begin
                  tx_in        = head.item.byte_value;
                  bit_count_in = 4'd0;
                  drv_in       = 1'b1;
                  clk_in       = 1'b0;
                  dio_in       = head.item.byte_value[0];
                  phase_in     = ledsbm_pkg::PH_WR_LO;
               end
               ledsbm_pkg::KIND_READ: begin
                  bit_count_in = 4'd0;
                  if (!four_wire) begin
                     dio_in = 1'b1;
                     drv_in = 1'b0;
                  end
                  phase_in = ledsbm_pkg::PH_RD_REL;
               end
               default: begin
                  if (two_wire) begin
                     clk_in   = 1'b0;
                     phase_in = ledsbm_pkg::PH_SP2A;
                  end else begin
                     phase_in = ledsbm_pkg::PH_SP3A;
                  end
               end
            endcase
         end
      end else if (phase_ff != ledsbm_pkg::PH_IDLE) begin
         wait_in = wait_dec;
         if (wait_dec == '0) begin
            // Most steps move on to another phase; finishing steps override.
            wait_in = wait_load;
            case (phase_ff)
               ledsbm_pkg::PH_ST3A: begin
                  stb_in   = 1'b0;
                  phase_in = ledsbm_pkg::PH_ST3B;
               end
               ledsbm_pkg::PH_WR_LO: begin
                  tx_in        = {1'b0, tx_ff[7:1]};
                  bit_count_in = bit_next;
                  clk_in       = 1'b1;
                  phase_in     = ledsbm_pkg::PH_WR_HI;
               end
               ledsbm_pkg::PH_WR_HI: begin
                  if (bit_count_ff < ledsbm_pkg::BYTE_BITS) begin
                     clk_in   = 1'b0;
                     dio_in   = tx_ff[0];
                     phase_in = ledsbm_pkg::PH_WR_LO;
                  end else if (two_wire) begin
                     clk_in   = 1'b0;
                     dio_in   = 1'b1;
                     drv_in   = 1'b0;
                     phase_in = ledsbm_pkg::PH_ACK_LO;
                  end else begin
                     phase_in = ledsbm_pkg::PH_IDLE;
                     wait_in  = '0;
                     done_in  = 1'b1;
                  end
               end
               ledsbm_pkg::PH_ACK_LO: begin
                  ack_in   = ~head.item.serial_in;
                  clk_in   = 1'b1;
                  phase_in = ledsbm_pkg::PH_ACK_HI;
               end
               ledsbm_pkg::PH_ACK_HI: begin
                  clk_in   = 1'b0;
                  drv_in   = 1'b1;
                  phase_in = ledsbm_pkg::PH_IDLE;
                  wait_in  = '0;
                  done_in  = 1'b1;
               end
               ledsbm_pkg::PH_RD_REL: begin
                  clk_in   = 1'b0;
                  phase_in = ledsbm_pkg::PH_RD_LO;
               end
               ledsbm_pkg::PH_RD_LO: begin
                  clk_in       = 1'b1;
                  shift_in     = {shift_ff[6:0], head.item.serial_in};
                  bit_count_in = bit_next;
                  rv_in        = (bit_next == ledsbm_pkg::BYTE_BITS);
                  phase_in     = ledsbm_pkg::PH_RD_HI;
               end
               ledsbm_pkg::PH_RD_HI: begin
                  if (bit_count_ff < ledsbm_pkg::BYTE_BITS) begin
                     clk_in   = 1'b0;
                     phase_in = ledsbm_pkg::PH_RD_LO;
                  end else if (two_wire) begin
                     clk_in   = 1'b0;
                     dio_in   = 1'b1;
                     drv_in   = 1'b0;
                     phase_in = ledsbm_pkg::PH_ACK_LO;
                  end else begin
                     drv_in   = 1'b1;
                     phase_in = ledsbm_pkg::PH_IDLE;
                     wait_in  = '0;
                     done_in  = 1'b1;
                  end
               end
               ledsbm_pkg::PH_SP2A: begin
                  drv_in   = 1'b1;
                  dio_in   = 1'b0;
                  phase_in = ledsbm_pkg::PH_SP2B;
               end
               ledsbm_pkg::PH_SP2B: begin
                  clk_in   = 1'b1;
                  phase_in = ledsbm_pkg::PH_SP2C;
               end
               ledsbm_pkg::PH_SP2C: begin
                  dio_in   = 1'b1;
                  phase_in = ledsbm_pkg::PH_IDLE;
                  wait_in  = '0;
                  done_in  = 1'b1;
               end
               ledsbm_pkg::PH_SP3A: begin
                  stb_in   = 1'b1;
                  phase_in = ledsbm_pkg::PH_IDLE;
                  wait_in  = '0;
                  done_in  = 1'b1;
               end
               ledsbm_pkg::PH_ST2: begin
                  dio_in   = 1'b0;
                  phase_in = ledsbm_pkg::PH_IDLE;
                  wait_in  = '0;
                  done_in  = 1'b1;
               end
               default: begin
                  phase_in = ledsbm_pkg::PH_IDLE;
                  wait_in  = '0;
                  done_in  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ledsbm_pkg::PH_IDLE;
         bit_count_ff <= 4'd0;
         wait_ff      <= '0;
         shift_ff     <= 8'd0;
         tx_ff        <= 8'd0;
         clk_ff       <= 1'b1;
         dio_ff       <= 1'b1;
         stb_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         ack_ff       <= 1'b0;
         rv_ff        <= 1'b0;
         done_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            wait_ff      <= wait_in;
            shift_ff     <= shift_in;
            tx_ff        <= tx_in;
            clk_ff       <= clk_in;
            dio_ff       <= dio_in;
            stb_ff       <= stb_in;
            drv_ff       <= drv_in;
            ack_ff       <= ack_in;
            rv_ff        <= rv_in;
            done_ff      <= done_in;
            rej_ff       <= rej_in;
            valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_clk_out    = clk_ff;
   assign rsp_dio_out    = dio_ff;
   assign rsp_dio_drive  = drv_ff;
   assign rsp_stb_out    = stb_ff;
   assign rsp_busy_res   = (phase_ff != ledsbm_pkg::PH_IDLE);
   assign rsp_read_data  = shift_ff;
   assign rsp_read_valid = rv_ff;
   assign rsp_ack_ok     = ack_ff;
   assign rsp_op_done    = done_ff;
   assign rsp_rejected   = rej_ff;

endmodule

// ----- src/led_driver_serial_bus_master_unit.sv -----
// ----------------------------------------------------------------------------
// LED driver serial bus master
// Bit-level master for two-wire (with ack), three-wire and four-wire LED
// driver links, advanced one phase tick per request beat.
//
//   Channel   Direction  Ports                       Beat
//   req       in         req_valid / req_ready       one command or tick
//   rsp       out        rsp_valid / rsp_ready       pin levels and status
//   csr       in         csr_valid / csr_ready       one register write
//
// One request beat is taken per cycle and gives one response beat; the
// sequencer updates all state for a beat at once; throughput is one beat per
// cycle when not stalled; a beat passes the queue, then the result register.
// Reset is synchronous; the queue empties and the pins return high, driven.
// A stalled response blocks the sequencer; the two-entry queue keeps
// taking request beats until it is full.
// ----------------------------------------------------------------------------
module led_driver_serial_bus_master_unit #(
   parameter int DELAY_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [2:0]                             req_type,
   input  logic [7:0]                             req_byte_value,
   input  logic                                   req_serial_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_clk_out,
   output logic                                   rsp_dio_out,
   output logic                                   rsp_dio_drive,
   output logic                                   rsp_stb_out,
   output logic                                   rsp_busy_res,
   output logic [7:0]                             rsp_read_data,
   output logic                                   rsp_read_valid,
   output logic                                   rsp_ack_ok,
   output logic                                   rsp_op_done,
   output logic                                   rsp_rejected,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ledsbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ledsbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [1:0]           wire_mode_ff;
   logic [11:0]          half_period_ff;
   ledsbm_pkg::head_type head;
   logic                 pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wire_mode_ff   <= ledsbm_pkg::MODE_TWO_WIRE;
         half_period_ff <= 12'd100;
      end else if (csr_valid) begin
         case (csr_index)
            ledsbm_pkg::CSR_WIRE_MODE:   wire_mode_ff   <= csr_wdata[1:0];
            ledsbm_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   ledsbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_byte_value (req_byte_value),
      .req_serial_in  (req_serial_in),
      .head           (head),
      .pop            (pop)
   );

   ledsbm_back #(
      .DELAY_BITS (DELAY_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .wire_mode      (wire_mode_ff),
      .half_period    (half_period_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_clk_out    (rsp_clk_out),
      .rsp_dio_out    (rsp_dio_out),
      .rsp_dio_drive  (rsp_dio_drive),
      .rsp_stb_out    (rsp_stb_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_read_valid (rsp_read_valid),
      .rsp_ack_ok     (rsp_ack_ok),
      .rsp_op_done    (rsp_op_done),
      .rsp_rejected   (rsp_rejected)
   );

endmodule

// ----- sim/ledsbm_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED driver serial bus master result checker
// Watches the request, response and register channels of the serial bus
// master. It keeps its own model of the pin sequencer, queues the expected
// pin levels and status for every request beat, and compares each response
// beat against the oldest entry.
// ----------------------------------------------------------------------------
module ledsbm_result_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic [2:0]                             req_type,
   input  logic [7:0]                             req_byte_value,
   input  logic                                   req_serial_in,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic                                   rsp_clk_out,
   input  logic                                   rsp_dio_out,
   input  logic                                   rsp_dio_drive,
   input  logic                                   rsp_stb_out,
   input  logic                                   rsp_busy_res,
   input  logic [7:0]                             rsp_read_data,
   input  logic                                   rsp_read_valid,
   input  logic                                   rsp_ack_ok,
   input  logic                                   rsp_op_done,
   input  logic                                   rsp_rejected,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [ledsbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ledsbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                     fail_count,
   output int                                     pending_count
);

   typedef struct packed {
      logic       clk;
      logic       dio;
      logic       drv;
      logic       stb;
      logic       busy;
      logic [7:0] data;
      logic       rv;
      logic       ack;
      logic       done;
      logic       rej;
   } pin_beat_type;

   ledsbm_pkg::phase_type seq_phase;
   logic [3:0]            bits_done;
   logic [11:0]           delay_left;
   logic [7:0]            rx_shift;
   logic [7:0]            tx_shift;
   logic                  pin_clk;
   logic                  pin_dio;
   logic                  pin_stb;
   logic                  pin_drv;
   logic                  ack_low;
   logic [1:0]            mode_reg;
   logic [11:0]           half_reg;
   logic                  beat_done;
   logic                  beat_byte;
   pin_beat_type          levels_q[$];

   function automatic logic two_wire();
      return mode_reg == ledsbm_pkg::MODE_TWO_WIRE;
   endfunction

   // Modes two and three both select the separate data input.
   function automatic logic four_wire();
      return mode_reg[1];
   endfunction

   function automatic string beat_text(input pin_beat_type b);
      return $sformatf("clk %b dio %b drv %b stb %b busy %b data %h rv %b ack %b done %b rej %b",
                       b.clk, b.dio, b.drv, b.stb, b.busy, b.data, b.rv, b.ack, b.done, b.rej);
   endfunction

   task automatic clear_model();
      seq_phase  = ledsbm_pkg::PH_IDLE;
      bits_done  = '0;
      delay_left = '0;
      rx_shift   = '0;
      tx_shift   = '0;
      pin_clk    = 1'b1;
      pin_dio    = 1'b1;
      pin_stb    = 1'b1;
      pin_drv    = 1'b1;
      ack_low    = 1'b0;
      mode_reg   = ledsbm_pkg::MODE_TWO_WIRE;
      half_reg   = 12'd100;
   endtask

   // A zero half period still holds each phase for one tick.
   task automatic set_delay(input ledsbm_pkg::phase_type nxt);
      delay_left = (half_reg == 12'd0) ? 12'd1 : half_reg;
      seq_phase  = nxt;
   endtask

   task automatic end_op();
      seq_phase  = ledsbm_pkg::PH_IDLE;
      delay_left = '0;
      beat_done  = 1'b1;
   endtask

   task automatic float_dio();
      pin_dio = 1'b1;
      pin_drv = 1'b0;
   endtask

   task automatic launch(input logic [2:0] code, input logic [7:0] val);
      case (code)
         ledsbm_pkg::REQ_START: begin
            pin_drv = 1'b1;
            pin_clk = 1'b1;
            if (two_wire()) begin
               pin_dio = 1'b1;
               set_delay(ledsbm_pkg::PH_ST2);
            end else begin
               pin_dio = 1'b0;
               set_delay(ledsbm_pkg::PH_ST3A);
            end
         end
         ledsbm_pkg::REQ_WRITE: begin
            tx_shift  = val;
            bits_done = '0;
            pin_drv   = 1'b1;
            pin_clk   = 1'b0;
            pin_dio   = val[0];
            set_delay(ledsbm_pkg::PH_WR_LO);
         end
         ledsbm_pkg::REQ_READ: begin
            bits_done = '0;
            if (!four_wire()) float_dio();
            set_delay(ledsbm_pkg::PH_RD_REL);
         end
         default: begin
            if (two_wire()) begin
               pin_clk = 1'b0;
               set_delay(ledsbm_pkg::PH_SP2A);
            end else begin
               set_delay(ledsbm_pkg::PH_SP3A);
            end
         end
      endcase
   endtask

   task automatic step_phase(input logic sin);
      case (seq_phase)
         ledsbm_pkg::PH_ST2: begin
            pin_dio = 1'b0;
            end_op();
         end
         ledsbm_pkg::PH_ST3A: begin
            pin_stb = 1'b0;
            set_delay(ledsbm_pkg::PH_ST3B);
         end
         ledsbm_pkg::PH_ST3B: end_op();
         ledsbm_pkg::PH_WR_LO: begin
            tx_shift  = tx_shift >> 1;
            bits_done = bits_done + 4'd1;
            pin_clk   = 1'b1;
            set_delay(ledsbm_pkg::PH_WR_HI);
         end
         ledsbm_pkg::PH_WR_HI: begin
            if (bits_done < ledsbm_pkg::BYTE_BITS) begin
               pin_clk = 1'b0;
               pin_dio = tx_shift[0];
               set_delay(ledsbm_pkg::PH_WR_LO);
            end else if (two_wire()) begin
               pin_clk = 1'b0;
               float_dio();
               set_delay(ledsbm_pkg::PH_ACK_LO);
            end else begin
               end_op();
            end
         end
         ledsbm_pkg::PH_ACK_LO: begin
            ack_low = ~sin;
            pin_clk = 1'b1;
            set_delay(ledsbm_pkg::PH_ACK_HI);
         end
         ledsbm_pkg::PH_ACK_HI: begin
            pin_clk = 1'b0;
            pin_drv = 1'b1;
            end_op();
         end
         ledsbm_pkg::PH_RD_REL: begin
            pin_clk = 1'b0;
            set_delay(ledsbm_pkg::PH_RD_LO);
         end
         ledsbm_pkg::PH_RD_LO: begin
            pin_clk   = 1'b1;
            rx_shift  = {rx_shift[6:0], sin};
            bits_done = bits_done + 4'd1;
            if (bits_done == ledsbm_pkg::BYTE_BITS) beat_byte = 1'b1;
            set_delay(ledsbm_pkg::PH_RD_HI);
         end
         ledsbm_pkg::PH_RD_HI: begin
            if (bits_done < ledsbm_pkg::BYTE_BITS) begin
               pin_clk = 1'b0;
               set_delay(ledsbm_pkg::PH_RD_LO);
            end else if (two_wire()) begin
               pin_clk = 1'b0;
               float_dio();
               set_delay(ledsbm_pkg::PH_ACK_LO);
            end else begin
               pin_drv = 1'b1;
               end_op();
            end
         end
         ledsbm_pkg::PH_SP2A: begin
            pin_drv = 1'b1;
            pin_dio = 1'b0;
            set_delay(ledsbm_pkg::PH_SP2B);
         end
         ledsbm_pkg::PH_SP2B: begin
            pin_clk = 1'b1;
            set_delay(ledsbm_pkg::PH_SP2C);
         end
         ledsbm_pkg::PH_SP2C: begin
            pin_dio = 1'b1;
            end_op();
         end
         ledsbm_pkg::PH_SP3A: begin
            pin_stb = 1'b1;
            end_op();
         end
         default: end_op();
      endcase
   endtask

   task automatic predict_beat(input logic [2:0] code, input logic [7:0] val,
                               input logic sin, output pin_beat_type r);
      logic refused;
      refused   = 1'b0;
      beat_done = 1'b0;
      beat_byte = 1'b0;
      if (code >= ledsbm_pkg::REQ_START && code <= ledsbm_pkg::REQ_STOP) begin
         if (seq_phase != ledsbm_pkg::PH_IDLE) refused = 1'b1;
         else launch(code, val);
      end else if (seq_phase != ledsbm_pkg::PH_IDLE) begin
         // Tick and spare codes count the phase delay down.
         delay_left = delay_left - 12'd1;
         if (delay_left == 12'd0) step_phase(sin);
      end
      r.clk  = pin_clk;
      r.dio  = pin_dio;
      r.drv  = pin_drv;
      r.stb  = pin_stb;
      r.busy = (seq_phase != ledsbm_pkg::PH_IDLE);
      r.data = rx_shift;
      r.rv   = beat_byte;
      r.ack  = ack_low;
      r.done = beat_done;
      r.rej  = refused;
   endtask

   always @(posedge clock) begin : monitor
      pin_beat_type want;
      pin_beat_type got;
      if (reset) begin
         clear_model();
         levels_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ledsbm_pkg::CSR_WIRE_MODE) mode_reg = csr_wdata[1:0];
            else if (csr_index == ledsbm_pkg::CSR_HALF_PERIOD) half_reg = csr_wdata[11:0];
         end
         if (req_valid && req_ready) begin
            predict_beat(req_type, req_byte_value, req_serial_in, want);
            levels_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got.clk  = rsp_clk_out;
            got.dio  = rsp_dio_out;
            got.drv  = rsp_dio_drive;
            got.stb  = rsp_stb_out;
            got.busy = rsp_busy_res;
            got.data = rsp_read_data;
            got.rv   = rsp_read_valid;
            got.ack  = rsp_ack_ok;
            got.done = rsp_op_done;
            got.rej  = rsp_rejected;
            if (levels_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response beat with nothing pending: %s", $realtime,
                           beat_text(got));
               fail_count++;
            end else begin
               want = levels_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", beat_text(want));
                     $display("   actual   %s", beat_text(got));
                  end
                  fail_count++;
               end
            end
         end
      end
      pending_count = levels_q.size();
   end

endmodule

// ----- sim/tb_led_driver_serial_bus_master_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED driver serial bus master testbench
// Drives framed transactions (start, byte writes and reads, stop) in every
// wire mode and several half periods, with busy commands, spare codes and
// idle ticks mixed in. Both channels stall at random and the response side
// holds off once for a long stretch. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_led_driver_serial_bus_master_unit;

   localparam logic [1:0] MODE_THREE_WIRE = 2'd1;
   localparam logic [1:0] MODE_FOUR_WIRE  = 2'd2;
   localparam logic [1:0] MODE_FOUR_ALIAS = 2'd3;
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic [2:0]                             req_type;
   logic [7:0]                             req_byte_value;
   logic                                   req_serial_in;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic                                   rsp_clk_out;
   logic                                   rsp_dio_out;
   logic                                   rsp_dio_drive;
   logic                                   rsp_stb_out;
   logic                                   rsp_busy_res;
   logic [7:0]                             rsp_read_data;
   logic                                   rsp_read_valid;
   logic                                   rsp_ack_ok;
   logic                                   rsp_op_done;
   logic                                   rsp_rejected;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [ledsbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [ledsbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;
   int                                     fail_count;
   int                                     pending_count;

   int          send_idle_pct = 0;
   int          rcv_idle_pct  = 0;
   logic        hold_go       = 1'b0;
   logic        hold_taken    = 1'b0;
   int          hold_left     = 0;
   int          item_total    = 0;
   logic [1:0]  cur_mode      = ledsbm_pkg::MODE_TWO_WIRE;
   logic [11:0] cur_half      = 12'd100;

   led_driver_serial_bus_master_unit u_top (.*);

   ledsbm_result_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("[led_driver_serial_bus_master_unit] ERROR");
      $finish;
   end

   // The response side either holds off for a counted stretch or stalls at random.
   always @(negedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = 120;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic send_req(input logic [2:0] code, input logic [7:0] val, input logic sin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= code;
      req_byte_value <= val;
      req_serial_in  <= sin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_total++;
   endtask

   task automatic write_csr(input logic [ledsbm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [ledsbm_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, let every response come back, then cover the pipeline latency.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [11:0] half);
      logic [ledsbm_pkg::CSR_DATA_WIDTH-1:0] data;
      logic [31:0]                           junk;
      settle();
      // Upper bits of the mode write are junk; only the low two bits count.
      junk      = $urandom;
      data      = junk[ledsbm_pkg::CSR_DATA_WIDTH-1:0];
      data[1:0] = mode;
      write_csr(ledsbm_pkg::CSR_WIRE_MODE, data);
      write_csr(ledsbm_pkg::CSR_HALF_PERIOD, half);
      cur_mode = mode;
      cur_half = half;
   endtask

   function automatic int command_ticks(input logic [2:0] code);
      logic two;
      int   phases;
      int   h;
      two = (cur_mode == ledsbm_pkg::MODE_TWO_WIRE);
      h   = (cur_half == 12'd0) ? 1 : int'(cur_half);
      case (code)
         ledsbm_pkg::REQ_START: phases = two ? 1 : 2;
         ledsbm_pkg::REQ_WRITE: phases = two ? 18 : 16;
         ledsbm_pkg::REQ_READ:  phases = two ? 19 : 17;
         default:               phases = two ? 3 : 1;
      endcase
      return phases * h;
   endfunction

   // Advances a busy sequencer by n ticks; a stray command now and then gets rejected.
   task automatic run_ticks(input int n);
      int         left;
      logic [2:0] code;
      left = n;
      while (left > 0) begin
         if ($urandom_range(99) < 3) begin
            send_req(3'($urandom_range(ledsbm_pkg::REQ_STOP, ledsbm_pkg::REQ_START)),
                     8'($urandom), 1'($urandom));
         end else begin
            code = ($urandom_range(99) < 6) ?
                   3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)) : ledsbm_pkg::REQ_TICK;
            send_req(code, 8'($urandom), 1'($urandom));
            left--;
         end
      end
   endtask

   task automatic run_command(input logic [2:0] code, input logic [7:0] val);
      send_req(code, val, 1'($urandom));
      run_ticks(command_ticks(code));
   endtask

   task automatic run_transaction();
      int nbytes;
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(2))
            0: run_command(3'($urandom_range(ledsbm_pkg::REQ_STOP, ledsbm_pkg::REQ_START)),
                           8'($urandom));
            1: send_req(3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)), 8'($urandom),
                        1'($urandom));
            default: begin
               run_command(ledsbm_pkg::REQ_START, 8'($urandom));
               run_command(ledsbm_pkg::REQ_STOP, 8'($urandom));
            end
         endcase
      end else begin
         run_command(ledsbm_pkg::REQ_START, 8'($urandom));
         nbytes = $urandom_range(4, 1);
         repeat (nbytes)
            run_command($urandom_range(1) ? ledsbm_pkg::REQ_WRITE : ledsbm_pkg::REQ_READ,
                        8'($urandom));
         run_command(ledsbm_pkg::REQ_STOP, 8'($urandom));
      end
   endtask

   initial begin
      int          block_start;
      int          roll;
      logic [11:0] half;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = ledsbm_pkg::REQ_TICK;
      req_byte_value = '0;
      req_serial_in  = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = ledsbm_pkg::CSR_WIRE_MODE;
      csr_wdata      = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rcv_idle_pct  = 65;

      // Idle beats: a tick and a spare code do nothing.
      send_req(ledsbm_pkg::REQ_TICK, 8'hFF, 1'b1);
      send_req(REQ_SPARE_LAST, 8'h00, 1'b0);

      set_config(ledsbm_pkg::MODE_TWO_WIRE, 12'd1);
      run_command(ledsbm_pkg::REQ_START, 8'h00);
      run_command(ledsbm_pkg::REQ_WRITE, 8'h00);
      run_command(ledsbm_pkg::REQ_WRITE, 8'hFF);
      run_command(ledsbm_pkg::REQ_READ, 8'h00);
      run_command(ledsbm_pkg::REQ_STOP, 8'h00);
      // A command while the start is still running must be rejected.
      send_req(ledsbm_pkg::REQ_START, 8'h00, 1'b0);
      send_req(ledsbm_pkg::REQ_WRITE, 8'h5A, 1'b1);
      run_ticks(command_ticks(ledsbm_pkg::REQ_START));

      set_config(MODE_THREE_WIRE, 12'd0);
      run_command(ledsbm_pkg::REQ_START, 8'h00);
      run_command(ledsbm_pkg::REQ_WRITE, 8'hA5);
      run_command(ledsbm_pkg::REQ_READ, 8'h00);
      run_command(ledsbm_pkg::REQ_STOP, 8'h00);

      set_config(MODE_FOUR_WIRE, 12'd2);
      run_command(ledsbm_pkg::REQ_START, 8'h00);
      run_command(ledsbm_pkg::REQ_WRITE, 8'h3C);
      run_command(ledsbm_pkg::REQ_READ, 8'h00);
      run_command(ledsbm_pkg::REQ_STOP, 8'h00);

      set_config(MODE_FOUR_ALIAS, 12'd1);
      run_command(ledsbm_pkg::REQ_START, 8'h00);
      run_command(ledsbm_pkg::REQ_READ, 8'h00);
      run_command(ledsbm_pkg::REQ_STOP, 8'h00);

      set_config(ledsbm_pkg::MODE_TWO_WIRE, 12'd40);
      run_command(ledsbm_pkg::REQ_START, 8'h00);

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 20;
               rcv_idle_pct  = 65;
            end
            1: begin
               send_idle_pct = 65;
               rcv_idle_pct  = 20;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            roll = $urandom_range(99);
            if (roll < 10) half = 12'd0;
            else if (roll < 80) half = 12'($urandom_range(2, 1));
            else half = 12'($urandom_range(4, 3));
            set_config(2'(k), half);
            // The response side stalls long enough for the input queue to fill.
            if (regime == 0 && k == 0) hold_go = 1'b1;
            block_start = item_total;
            while (item_total - block_start < 60) run_transaction();
         end
      end

      settle();
      if (fail_count == 0 && pending_count == 0)
         $display("[led_driver_serial_bus_master_unit] OK");
      else
         $display("[led_driver_serial_bus_master_unit] ERROR");
      $finish;
   end

endmodule
